>>> rtl/core/bb3_pkg.sv
// shared constants and types for the 3x3 box blur stream
package bb3_pkg;

  // line store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int LINE_W     = 16;

  // field widths
  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int SUM_W      = 12;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // reset frame size
  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [FW_W-1:0] WIDTH_MIN    = 11'd3;
  localparam logic [FH_W-1:0] HEIGHT_MIN   = 16'd3;

  // divide by 9 as multiply by ceil(2^16 / 9), exact for sums up to 2295
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_end;
  } result_t;

endpackage

>>> rtl/core/bb3_pix_if.sv
// pixel input channel
interface bb3_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

>>> rtl/core/bb3_res_if.sv
// filtered result channel
interface bb3_res_if;
  logic                      valid;
  logic                      ready;
  logic [bb3_pkg::PIX_W-1:0] mean_value;
  logic [bb3_pkg::COL_W-1:0] out_col;
  logic [bb3_pkg::ROW_W-1:0] out_row;
  logic                      frame_end;

  modport source (output valid, output mean_value, output out_col, output out_row,
                  output frame_end, input ready);
  modport sink   (input valid, input mean_value, input out_col, input out_row,
                  input frame_end, output ready);
endinterface

>>> rtl/core/bb3_cfg_if.sv
// register write channel
interface bb3_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bb3_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [bb3_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

>>> rtl/core/bb3_ram.sv
// generic simple dual port ram with registered read
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bb3_out_fifo.sv
// small result queue between the filter pipeline and the output channel
module bb3_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  bb3_pkg::result_t               push_data,
  input  logic                           pop,
  output logic                           not_empty,
  output bb3_pkg::result_t               head,
  output logic [bb3_pkg::FIFO_CNT_W-1:0] count
);

  bb3_pkg::result_t                  mem [bb3_pkg::FIFO_DEPTH];
  logic [bb3_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [bb3_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic                              do_pop;

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/box_blur_3x3_stream_top.sv
// 3x3 box blur over a raster pixel stream, top level
//
// Pixels enter on pix_in in raster order, one transaction per pixel, for a
// frame of frame_width x frame_height set through cfg (index 0 width, index 1
// height). The frame size is sampled at the first pixel of each frame; the
// width is clamped to 3..1024, the height to at least 3. For every pixel not
// on the one-pixel border, res carries the truncated mean of its 3x3
// neighbourhood, its column and row, and frame_end on the frame's last one.
// Border pixels give no transaction on res.
// Throughput is one pixel per cycle while the output queue has room: the two
// previous rows sit in one 1024 x 16 line ram read at the incoming column and
// written back in the next cycle, so each pixel costs a single read and a
// single write of that ram. The result for pixel (c, r) is computed when pixel
// (c+1, r+1) is taken and passes through the stage 1 and stage 2 registers
// into the output queue, from which res presents it.
// When res stalls, results collect in a four-entry queue; pix_in stays ready
// while the queue plus results in flight leave room, so a stalled receiver
// holds off input within a few transactions without losing anything.
// Reset (rst, synchronous) empties the pipeline and queue, zeroes the
// position counters and loads the size registers with 640 x 480. The line
// ram needs no clearing: no result uses an entry before it is written.
module box_blur_3x3_stream_top (
  input  logic       clk,
  input  logic       rst,
  bb3_cfg_if.sink    cfg,
  bb3_pix_if.sink    pix_in,
  bb3_res_if.source  res
);

  // configuration registers and latched frame size
  logic [bb3_pkg::FW_W-1:0]   frame_width;
  logic [bb3_pkg::FH_W-1:0]   frame_height;
  logic [bb3_pkg::FW_W-1:0]   used_width;
  logic [bb3_pkg::FH_W-1:0]   used_height;

  // input position
  logic [bb3_pkg::COL_W-1:0]  col_count;
  logic [bb3_pkg::ROW_W-1:0]  row_count;

  // accept stage decode
  logic                       accept;
  logic                       frame_start;
  logic [bb3_pkg::FW_W-1:0]   clamp_width;
  logic [bb3_pkg::FH_W-1:0]   clamp_height;
  logic [bb3_pkg::FW_W-1:0]   eff_width;
  logic [bb3_pkg::FH_W-1:0]   eff_height;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       has_result;
  logic                       last_of_frame;

  // stage 1: line ram read in flight
  logic                       s1_valid;
  logic                       s1_res;
  logic [bb3_pkg::PIX_W-1:0]  s1_pix;
  logic [bb3_pkg::ADDR_W-1:0] s1_addr;
  logic [bb3_pkg::COL_W-1:0]  s1_col;
  logic [bb3_pkg::ROW_W-1:0]  s1_row;
  logic                       s1_fe;

  // line ram and window
  logic [bb3_pkg::LINE_W-1:0] line_rdata;
  logic [bb3_pkg::PIX_W-1:0]  top;
  logic [bb3_pkg::PIX_W-1:0]  mid;
  logic [bb3_pkg::PIX_W-1:0]  window_regs [6];
  logic [bb3_pkg::SUM_W-1:0]  sum;

  // stage 2: sum registered
  logic                       s2_valid;
  logic [bb3_pkg::SUM_W-1:0]  s2_sum;
  logic [bb3_pkg::COL_W-1:0]  s2_col;
  logic [bb3_pkg::ROW_W-1:0]  s2_row;
  logic                       s2_fe;
  logic [bb3_pkg::SUM_W+bb3_pkg::RECIP_W-1:0] prod;
  bb3_pkg::result_t           push_data;

  // output queue
  logic                              fifo_not_empty;
  bb3_pkg::result_t                  fifo_head;
  logic [bb3_pkg::FIFO_CNT_W-1:0]    fifo_count;
  logic [bb3_pkg::FIFO_CNT_W-1:0]    reserved;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_RESET;
      frame_height <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.wr_index)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.wr_data[bb3_pkg::FW_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.wr_data[bb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // input credit: queue entries plus results still in the pipeline
  assign reserved = fifo_count
                  + bb3_pkg::FIFO_CNT_W'(s1_valid && s1_res)
                  + bb3_pkg::FIFO_CNT_W'(s2_valid);
  assign pix_in.ready = (reserved < bb3_pkg::FIFO_CNT_W'(bb3_pkg::FIFO_DEPTH));
  assign accept = pix_in.valid && pix_in.ready;

  // frame size taken at the first pixel of a frame
  assign frame_start  = (col_count == '0) && (row_count == '0);
  assign clamp_width  = (frame_width < bb3_pkg::WIDTH_MIN) ? bb3_pkg::WIDTH_MIN :
                        (frame_width > bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH)) ?
                        bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH) : frame_width;
  assign clamp_height = (frame_height < bb3_pkg::HEIGHT_MIN) ? bb3_pkg::HEIGHT_MIN
                                                              : frame_height;
  assign eff_width    = frame_start ? clamp_width  : used_width;
  assign eff_height   = frame_start ? clamp_height : used_height;

  // position decode
  assign col_wrap      = ({1'b0, col_count} + 11'd1) >= eff_width;
  assign row_wrap      = ({1'b0, row_count} + 17'd1) >= {1'b0, eff_height};
  assign has_result    = (col_count >= 10'd2) && (row_count >= 16'd2);
  assign last_of_frame = ({1'b0, col_count} == (eff_width - 11'd1))
                      && (row_count == (eff_height - 16'd1));

  // counters and latched size
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      used_width  <= bb3_pkg::WIDTH_RESET;
      used_height <= bb3_pkg::HEIGHT_RESET;
    end else if (accept) begin
      used_width  <= eff_width;
      used_height <= eff_height;
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + 10'd1;
      end
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res  <= has_result;
      s1_pix  <= pix_in.pixel_value;
      s1_addr <= bb3_pkg::ADDR_W'(col_count);
      s1_col  <= col_count - 10'd1;
      s1_row  <= row_count - 16'd1;
      s1_fe   <= last_of_frame;
    end
  end

  // two rows per entry: upper byte two rows back, lower byte previous row
  bb3_ram #(
    .WIDTH (bb3_pkg::LINE_W),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata ({mid, s1_pix}),
    .raddr (bb3_pkg::ADDR_W'(col_count)),
    .rdata (line_rdata)
  );

  assign top = line_rdata[bb3_pkg::LINE_W-1:bb3_pkg::PIX_W];
  assign mid = line_rdata[bb3_pkg::PIX_W-1:0];

  // neighbourhood sum
  assign sum = bb3_pkg::SUM_W'(window_regs[0]) + bb3_pkg::SUM_W'(window_regs[1])
             + bb3_pkg::SUM_W'(window_regs[2]) + bb3_pkg::SUM_W'(window_regs[3])
             + bb3_pkg::SUM_W'(window_regs[4]) + bb3_pkg::SUM_W'(window_regs[5])
             + bb3_pkg::SUM_W'(top) + bb3_pkg::SUM_W'(mid) + bb3_pkg::SUM_W'(s1_pix);

  // window shift: two previous columns of top, middle and bottom rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else if (s1_valid) begin
      window_regs[0] <= window_regs[3];
      window_regs[1] <= window_regs[4];
      window_regs[2] <= window_regs[5];
      window_regs[3] <= top;
      window_regs[4] <= mid;
      window_regs[5] <= s1_pix;
    end
  end

  // stage 2 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sum <= sum;
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_fe  <= s1_fe;
    end
  end

  // divide by nine
  assign prod = {{bb3_pkg::RECIP_W{1'b0}}, s2_sum}
              * {{bb3_pkg::SUM_W{1'b0}}, bb3_pkg::RECIP_NINE};

  assign push_data.mean_value = prod[bb3_pkg::RECIP_SH+bb3_pkg::PIX_W-1:bb3_pkg::RECIP_SH];
  assign push_data.out_col    = s2_col;
  assign push_data.out_row    = s2_row;
  assign push_data.frame_end  = s2_fe;

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .pop       (res.ready),
    .not_empty (fifo_not_empty),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  // output channel
  assign res.valid      = fifo_not_empty;
  assign res.mean_value = fifo_head.mean_value;
  assign res.out_col    = fifo_head.out_col;
  assign res.out_row    = fifo_head.out_row;
  assign res.frame_end  = fifo_head.frame_end;

  // queue never asked to take more than it holds
  assert property (@(posedge clk) disable iff (rst)
    reserved <= bb3_pkg::FIFO_CNT_W'(bb3_pkg::FIFO_DEPTH))
    else $error("output queue overcommitted");

  // write back never targets the column being read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && accept) |-> (s1_addr != bb3_pkg::ADDR_W'(col_count)))
    else $error("line ram read and write collide");

  // column counter stays inside the latched width
  assert property (@(posedge clk) disable iff (rst)
    !frame_start |-> ({1'b0, col_count} < used_width))
    else $error("column counter beyond frame width");

  // last column of a row wraps the column counter
  assert property (@(posedge clk) disable iff (rst)
    (accept && col_wrap) |=> (col_count == '0))
    else $error("column counter failed to wrap");

endmodule
